/* rtl/bld_pkg.sv */
package bld_pkg;

  // Field and register widths
  localparam int unsigned LevelsW   = 4;
  localparam int unsigned PeriodW   = 8;
  localparam int unsigned IntervalW = 10;
  localparam int unsigned StepW     = 7;
  localparam int unsigned BrightW   = 7;
  localparam int unsigned LedOutW   = 10;
  localparam int unsigned SelOutW   = 4;

  // Default LED count
  localparam int unsigned NumLedsDef = 10;

  // Product of period and brightness, and the scaled counter threshold
  localparam int unsigned ProdW = 16;
  localparam int unsigned PercentScale = 100;

  // Brightness ceiling in percent
  localparam logic [BrightW-1:0] BrightMax = BrightW'(PercentScale);

  // Button positions inside the level field
  localparam int unsigned BtnSelDown = 0;
  localparam int unsigned BtnSelUp   = 1;
  localparam int unsigned BtnDimDown = 2;
  localparam int unsigned BtnDimUp   = 3;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CfgPwmPeriod      = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgSampleInterval = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgBrightStep     = CfgIdxW'(2);

  localparam logic [PeriodW-1:0]   PwmPeriodRst      = PeriodW'(20);
  localparam logic [IntervalW-1:0] SampleIntervalRst = IntervalW'(50);
  localparam logic [StepW-1:0]     BrightStepRst     = StepW'(10);

  // Selection and level of the panel, handed to the result stage
  typedef struct packed {
    logic [SelOutW-1:0] selected_led;
    logic [BrightW-1:0] selected_level;
  } panel_view_t;

endpackage

/* rtl/bld_if.sv */
interface bld_in_if import bld_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LevelsW-1:0] button_levels;
  logic               run_panel;

  modport source (output valid, output button_levels, output run_panel, input ready);
  modport sink   (input valid, input button_levels, input run_panel, output ready);
endinterface

interface bld_out_if import bld_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LedOutW-1:0] led_outputs;
  logic [SelOutW-1:0] selected_led;
  logic [BrightW-1:0] selected_level;

  modport source (output valid, output led_outputs, output selected_led,
                  output selected_level, input ready);
  modport sink   (input valid, input led_outputs, input selected_led,
                  input selected_level, output ready);
endinterface

interface bld_cfg_if import bld_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/bld_panel.sv */
module bld_panel import bld_pkg::*; #(
  parameter int unsigned NumLeds = NumLedsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic [LevelsW-1:0]   button_levels_i,
  input  logic                 run_panel_i,
  input  logic [IntervalW-1:0] sample_interval_i,
  input  logic [StepW-1:0]     brightness_step_i,
  output logic [BrightW-1:0]   bright_o [NumLeds],
  output panel_view_t          view_o
);

  localparam int unsigned SelW = $clog2(NumLeds);

  logic [IntervalW-1:0] sample_cnt_q, sample_cnt_d;
  logic [LevelsW-1:0]   pressed_q, pressed_d;
  logic [1:0]           last_q, last_d;
  logic [SelW-1:0]      sel_q, sel_d;
  logic [BrightW-1:0]   bright_q [NumLeds];

  logic [IntervalW:0]   sample_next;
  logic                 rise_down, rise_up;
  logic [SelW-1:0]      sel_dn, sel_a, sel_up;
  logic [SelW:0]        sel_a_inc;
  logic [BrightW-1:0]   b_cur, b_dim, b_new;
  logic [BrightW:0]     b_sum;

  // Latch the inverted levels once per sample interval
  always_comb begin
    sample_next = {1'b0, sample_cnt_q} + (IntervalW+1)'(1);
    if (sample_next >= {1'b0, sample_interval_i}) begin
      sample_cnt_d = '0;
      pressed_d    = ~button_levels_i;
    end else begin
      sample_cnt_d = sample_next[IntervalW-1:0];
      pressed_d    = pressed_q;
    end
  end

  // Detect new presses of the selection buttons
  assign rise_down = run_panel_i && pressed_d[BtnSelDown] && !last_q[0];
  assign rise_up   = run_panel_i && pressed_d[BtnSelUp] && !last_q[1];
  assign last_d    = run_panel_i ? {pressed_d[BtnSelUp], pressed_d[BtnSelDown]} : last_q;

  // Move the selection down, then up, wrapping at both ends
  always_comb begin
    sel_dn    = (sel_q == '0) ? SelW'(NumLeds - 1) : sel_q - SelW'(1);
    sel_a     = rise_down ? sel_dn : sel_q;
    sel_a_inc = {1'b0, sel_a} + (SelW+1)'(1);
    sel_up    = (sel_a_inc >= (SelW+1)'(NumLeds)) ? '0 : sel_a_inc[SelW-1:0];
    sel_d     = rise_up ? sel_up : sel_a;
  end

  // Dim first, then brighten, saturating at zero and full
  always_comb begin
    b_cur = bright_q[sel_d];
    b_dim = b_cur;
    if (run_panel_i && pressed_d[BtnDimDown]) begin
      b_dim = (b_cur > brightness_step_i) ? b_cur - brightness_step_i : '0;
    end
    b_sum = {1'b0, b_dim} + {1'b0, brightness_step_i};
    b_new = b_dim;
    if (run_panel_i && pressed_d[BtnDimUp]) begin
      b_new = (b_sum > {1'b0, BrightMax}) ? BrightMax : b_sum[BrightW-1:0];
    end
  end

  // Hand the updated table to the PWM lanes
  for (genvar i = 0; i < NumLeds; i++) begin : g_bright
    assign bright_o[i] = (SelW'(i) == sel_d) ? b_new : bright_q[i];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        bright_q[i] <= '0;
      end else if (advance_i) begin
        bright_q[i] <= bright_o[i];
      end
    end
  end

  assign view_o.selected_led   = SelOutW'(sel_d);
  assign view_o.selected_level = b_new;

  // Hold panel state between transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_cnt_q <= '0;
      pressed_q    <= '0;
      last_q       <= '0;
      sel_q        <= '0;
    end else if (advance_i) begin
      sample_cnt_q <= sample_cnt_d;
      pressed_q    <= pressed_d;
      last_q       <= last_d;
      sel_q        <= sel_d;
    end
  end

endmodule

/* rtl/bld_pwm.sv */
module bld_pwm import bld_pkg::*; #(
  parameter int unsigned NumLeds = NumLedsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic [PeriodW-1:0] pwm_period_i,
  input  logic [BrightW-1:0] bright_i [NumLeds],
  output logic [NumLeds-1:0] leds_o
);

  logic [PeriodW-1:0] cnt_q, cnt_d;
  logic [PeriodW:0]   cnt_next;
  logic [ProdW-1:0]   threshold;

  // LED on while counter < floor(period * level / 100),
  // i.e. while period * level >= 100 * (counter + 1)
  assign cnt_next  = {1'b0, cnt_q} + (PeriodW+1)'(1);
  assign threshold = ProdW'(cnt_next) * ProdW'(PercentScale);

  for (genvar i = 0; i < NumLeds; i++) begin : g_lane
    logic [ProdW-1:0] prod;
    assign prod      = ProdW'(pwm_period_i) * ProdW'(bright_i[i]);
    assign leds_o[i] = (prod >= threshold);
  end

  // Advance the shared period counter, wrap at the period
  assign cnt_d = (cnt_next >= {1'b0, pwm_period_i}) ? '0 : cnt_next[PeriodW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (advance_i) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/button_led_pwm_dimmer.sv */
// LED PWM dimmer with a four-button panel.
// in_i carries one transaction per 1 ms tick: the raw active-low button levels
// and run_panel, which runs the selection and brightness step for that tick.
// out_o returns one transaction per tick: the PWM drive bits of all LEDs, the
// selected LED index and its brightness in percent.
// cfg_i writes pwm_period (index 0), sample_interval (1) and brightness_step
// (2); other indexes are ignored. Its ready is always high. Write only while
// no transaction is in flight.
// A tick accepted on in_i is captured in the input register; its result is
// computed from that register and, once the result register is free, is
// captured there and shows on out_o. Throughput: one tick per cycle while
// out_o takes each result; the input register and the result register each
// move on as soon as the next stage is free.
// When out_o stalls, the result register holds, the input register fills, and
// in_i.ready drops only once both are occupied.
// Reset clears both pipeline stages, all brightness levels, the PWM and sample
// counters, the pressed flags and the selection, and restores the registers
// to period 20, sample interval 50 and step 10.
module button_led_pwm_dimmer import bld_pkg::*; #(
  parameter int unsigned NumLeds = NumLedsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  bld_in_if.sink    in_i,
  bld_out_if.source out_o,
  bld_cfg_if.sink   cfg_i
);

  logic [PeriodW-1:0]   pwm_period_q;
  logic [IntervalW-1:0] sample_interval_q;
  logic [StepW-1:0]     brightness_step_q;

  logic               in_v_q;
  logic [LevelsW-1:0] levels_q;
  logic               run_q;

  logic               out_v_q;
  logic [LedOutW-1:0] leds_out_q, leds_out_d;
  panel_view_t        view_q, view_d;

  logic               advance;
  logic [BrightW-1:0] bright [NumLeds];
  logic [NumLeds-1:0] leds;

  // Take configuration writes at any time
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_period_q      <= PwmPeriodRst;
      sample_interval_q <= SampleIntervalRst;
      brightness_step_q <= BrightStepRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgPwmPeriod:      pwm_period_q      <= cfg_i.data[PeriodW-1:0];
        CfgSampleInterval: sample_interval_q <= cfg_i.data[IntervalW-1:0];
        CfgBrightStep:     brightness_step_q <= cfg_i.data[StepW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the input stage when the result register is free
  assign advance    = in_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !in_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      levels_q <= in_i.button_levels;
      run_q    <= in_i.run_panel;
    end
  end

  bld_panel #(.NumLeds(NumLeds)) u_panel (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .advance_i         (advance),
    .button_levels_i   (levels_q),
    .run_panel_i       (run_q),
    .sample_interval_i (sample_interval_q),
    .brightness_step_i (brightness_step_q),
    .bright_o          (bright),
    .view_o            (view_d)
  );

  bld_pwm #(.NumLeds(NumLeds)) u_pwm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .pwm_period_i (pwm_period_q),
    .bright_i     (bright),
    .leds_o       (leds)
  );

  // Drop LEDs beyond the output field, zero-fill when there are fewer
  for (genvar j = 0; j < LedOutW; j++) begin : g_led_out
    if (j < NumLeds) begin : g_on
      assign leds_out_d[j] = leds[j];
    end else begin : g_off
      assign leds_out_d[j] = 1'b0;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || out_o.ready) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      leds_out_q <= leds_out_d;
      view_q     <= view_d;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.led_outputs    = leds_out_q;
  assign out_o.selected_led   = view_q.selected_led;
  assign out_o.selected_level = view_q.selected_level;

endmodule
